FILE: hw/rtl/pa_pkg.sv
package pa_pkg;

	localparam int CORDIC_ITERATIONS = 30;
	localparam int FRACTION_BITS = 29;
	localparam int WB = 34;
	localparam int ADDR_BITS = 2;
	localparam logic [ADDR_BITS-1:0] ADDR_LATITUDE = 2'd0;

	localparam logic signed [WB-1:0] PI_W = 34'sd3373259426;
	localparam logic signed [WB-1:0] HALFPI_W = 34'sd1686629713;
	localparam logic signed [WB-1:0] GAIN_K = 34'sd652032874;
	localparam logic signed [WB-1:0] PI_F = 34'sd1686629713;
	localparam logic signed [WB-1:0] TWOPI_F = 34'sd3373259426;

	typedef logic signed [WB-1:0] word_t;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
		logic  neg;
	} rot_t;

	function automatic word_t atan_w(input int i);
		word_t t;
		case (i)
			0: t = 34'sd843314857;
			1: t = 34'sd497837829;
			2: t = 34'sd263043837;
			3: t = 34'sd133525159;
			4: t = 34'sd67021687;
			5: t = 34'sd33543516;
			6: t = 34'sd16775851;
			7: t = 34'sd8388437;
			8: t = 34'sd4194283;
			9: t = 34'sd2097149;
			10: t = 34'sd1048576;
			11: t = 34'sd524288;
			12: t = 34'sd262144;
			13: t = 34'sd131072;
			14: t = 34'sd65536;
			15: t = 34'sd32768;
			16: t = 34'sd16384;
			17: t = 34'sd8192;
			18: t = 34'sd4096;
			19: t = 34'sd2048;
			20: t = 34'sd1024;
			21: t = 34'sd512;
			22: t = 34'sd256;
			23: t = 34'sd128;
			24: t = 34'sd64;
			25: t = 34'sd32;
			26: t = 34'sd16;
			27: t = 34'sd8;
			28: t = 34'sd4;
			29: t = 34'sd2;
			30: t = 34'sd1;
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic word_t mulq(input word_t a, input word_t b);
		logic signed [2*WB-1:0] p;
		p = a * b + (68'sd1 <<< 29);
		return word_t'(p >>> 30);
	endfunction

endpackage

FILE: hw/rtl/pa_cell.sv
module pa_cell #(
	parameter int STEP = 0,
	parameter bit VECTOR = 1'b0,
	parameter int W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  pa_pkg::rot_t in_a,
	input  logic [W-1:0] side_in,
	output pa_pkg::rot_t out_a,
	output logic [W-1:0] side_out
);
	import pa_pkg::*;

	rot_t nxt;
	logic dir;

	always_comb begin
		dir = VECTOR ? (in_a.y > 0) : (in_a.z >= 0);
		nxt = in_a;
		if (VECTOR ? dir : dir) begin
			if (VECTOR) begin
				nxt.x = in_a.x + (in_a.y >>> STEP);
				nxt.y = in_a.y - (in_a.x >>> STEP);
				nxt.z = in_a.z + atan_w(STEP);
			end else begin
				nxt.x = in_a.x - (in_a.y >>> STEP);
				nxt.y = in_a.y + (in_a.x >>> STEP);
				nxt.z = in_a.z - atan_w(STEP);
			end
		end else begin
			if (VECTOR) begin
				nxt.x = in_a.x - (in_a.y >>> STEP);
				nxt.y = in_a.y + (in_a.x >>> STEP);
				nxt.z = in_a.z - atan_w(STEP);
			end else begin
				nxt.x = in_a.x + (in_a.y >>> STEP);
				nxt.y = in_a.y - (in_a.x >>> STEP);
				nxt.z = in_a.z + atan_w(STEP);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_a <= '0;
			side_out <= '0;
		end else if (en) begin
			out_a <= nxt;
			side_out <= side_in;
		end
	end
endmodule

FILE: hw/rtl/parallactic_angle.sv
// parallactic angle pipeline
// input channel: hour_angle, declination with in_valid / in_ready
// output channel: angle, at_pole with out_valid / out_ready
// latitude is written over the apb port, address 0, and read back there
// one transaction accepted per cycle; every stage holds when the output
// register holds a result that the receiver has not taken
// stages: 2 reduction stages, cordic_iterations rotation cells,
// 3 product stages, 1 quadrant stage, cordic_iterations vectoring cells,
// 1 output stage, 67 register stages with 30 iterations
// throughput: one result per cycle while out_ready stays high
// a stall freezes the whole chain; in_ready follows out_ready or an empty output
// reset clears all valid flags and latitude to zero
module parallactic_angle (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] hour_angle,
	input  logic signed [30:0] declination,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] angle,
	output logic at_pole,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [pa_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import pa_pkg::*;

	localparam int N = CORDIC_ITERATIONS;

	logic signed [30:0] latitude_q;
	logic en;

	assign pready = 1'b1;
	assign prdata = {{1{latitude_q[30]}}, latitude_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latitude_q <= '0;
		end else if (psel && penable && pwrite && paddr == ADDR_LATITUDE) begin
			latitude_q <= pwdata[30:0];
		end
	end

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// reduction: remainder by 2*pi (quotient at most one), shift to q30
	function automatic word_t reduce(input word_t r);
		word_t v;
		v = r;
		if (v >= TWOPI_F) v = v - TWOPI_F;
		else if (v <= -TWOPI_F) v = v + TWOPI_F;
		if (v > PI_F) v = v - TWOPI_F;
		if (v < -PI_F) v = v + TWOPI_F;
		return v <<< 1;
	endfunction

	function automatic rot_t fold(input word_t t);
		rot_t r;
		r.x = GAIN_K;
		r.y = '0;
		r.z = t;
		r.neg = 1'b0;
		if (t > HALFPI_W) begin
			r.z = t - PI_W;
			r.neg = 1'b1;
		end else if (t < -HALFPI_W) begin
			r.z = t + PI_W;
			r.neg = 1'b1;
		end
		return r;
	endfunction

	logic v_s1, v_s2;
	word_t h_s1, d_s1, l_s1;
	rot_t rh_s2, rd_s2, rl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1 <= reduce(word_t'(hour_angle));
			d_s1 <= reduce(word_t'(declination));
			l_s1 <= reduce(word_t'(latitude_q));
			rh_s2 <= fold(h_s1);
			rd_s2 <= fold(d_s1);
			rl_s2 <= fold(l_s1);
		end
	end

	rot_t ch [0:N];
	rot_t cd [0:N];
	rot_t cl [0:N];
	logic vr [0:N];
	assign ch[0] = rh_s2;
	assign cd[0] = rd_s2;
	assign cl[0] = rl_s2;
	assign vr[0] = v_s2;

	for (genvar i = 0; i < N; i++) begin : g_rot
		logic [0:0] vh, vd, vl;
		pa_cell #(.STEP(i), .VECTOR(1'b0), .W(1)) u_h (
			.clk(clk), .arst_n(arst_n), .en(en), .in_a(ch[i]),
			.side_in(vr[i]), .out_a(ch[i+1]), .side_out(vh));
		pa_cell #(.STEP(i), .VECTOR(1'b0), .W(1)) u_d (
			.clk(clk), .arst_n(arst_n), .en(en), .in_a(cd[i]),
			.side_in(vr[i]), .out_a(cd[i+1]), .side_out(vd));
		pa_cell #(.STEP(i), .VECTOR(1'b0), .W(1)) u_l (
			.clk(clk), .arst_n(arst_n), .en(en), .in_a(cl[i]),
			.side_in(vr[i]), .out_a(cl[i+1]), .side_out(vl));
		assign vr[i+1] = vh[0] & vd[0] & vl[0];
	end

	word_t sh, chh, sd, cdd, sp, cp;
	assign sh  = ch[N].neg ? -ch[N].y : ch[N].y;
	assign chh = ch[N].neg ? -ch[N].x : ch[N].x;
	assign sd  = cd[N].neg ? -cd[N].y : cd[N].y;
	assign cdd = cd[N].neg ? -cd[N].x : cd[N].x;
	assign sp  = cl[N].neg ? -cl[N].y : cl[N].y;
	assign cp  = cl[N].neg ? -cl[N].x : cl[N].x;

	logic v_m1, v_m2, v_m3, v_m4;
	word_t s_m1, a_m1, b_m1, chh_m1;
	word_t s_m2, a_m2, b_m2;
	word_t s_m3, c_m3;
	rot_t q_m4;
	logic pole_m4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
			v_m4 <= 1'b0;
		end else if (en) begin
			v_m1 <= vr[N];
			v_m2 <= v_m1;
			v_m3 <= v_m2;
			v_m4 <= v_m3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_m1 <= mulq(cp, sh);
			a_m1 <= mulq(sp, cdd);
			b_m1 <= mulq(cp, sd);
			chh_m1 <= chh;
			s_m2 <= s_m1;
			a_m2 <= a_m1;
			b_m2 <= mulq(b_m1, chh_m1);
			s_m3 <= s_m2;
			c_m3 <= a_m2 - b_m2;
			pole_m4 <= (s_m3 == 0) && (c_m3 == 0);
			q_m4.neg <= 1'b0;
			if (c_m3 < 0) begin
				q_m4.x <= -c_m3;
				q_m4.y <= -s_m3;
				q_m4.z <= (s_m3 >= 0) ? PI_W : -PI_W;
			end else begin
				q_m4.x <= c_m3;
				q_m4.y <= s_m3;
				q_m4.z <= '0;
			end
		end
	end

	rot_t cv [0:N];
	logic [1:0] sv [0:N];
	assign cv[0] = q_m4;
	assign sv[0] = {v_m4, pole_m4};

	for (genvar i = 0; i < N; i++) begin : g_vec
		pa_cell #(.STEP(i), .VECTOR(1'b1), .W(2)) u_v (
			.clk(clk), .arst_n(arst_n), .en(en), .in_a(cv[i]),
			.side_in(sv[i]), .out_a(cv[i+1]), .side_out(sv[i+1]));
	end

	word_t zf;
	always_comb begin
		zf = cv[N].z >>> 1;
		if (cv[N].z[0]) zf = zf + 1;
		if (zf > PI_F) zf = PI_F;
		if (zf < -PI_F) zf = -PI_F;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= sv[N][1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			at_pole <= sv[N][0];
			angle <= sv[N][0] ? '0 : zf[31:0];
		end
	end

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(angle))
		else $error("result lost under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
	a_pole: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_pole |-> angle == 0)
		else $error("pole result not zero");
endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import pa_pkg::*;

	localparam int NITER = 30;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PIPE_DRAIN = 80;
	localparam int RANDOM_ITEMS = 2000;

	typedef struct {
		logic [31:0] angle;
		logic        pole;
	} pa_result_t;

	typedef struct {
		logic [31:0] ha;
		logic [30:0] dec;
	} pa_coord_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [31:0] hour_angle = '0;
	logic signed [30:0] declination = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] angle;
	logic at_pole;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	longint atan_q30[NITER];
	longint pi_q30, halfpi_q30, pi_q29, gain_q30;
	logic [30:0] lat_reg = '0;
	pa_result_t angle_q[$];
	int fails = 0;
	int wd = 0;
	bit steady = 0;

	parallactic_angle uut (.*);

	always #2 clk = ~clk;

	function automatic longint arctan_series(longint unsigned p, int sh, longint unsigned dv);
		longint sum = 0;
		longint unsigned k = 0;
		longint t;
		while (p != 0) begin
			t = longint'(p / (2 * k + 1));
			sum += k[0] ? -t : t;
			if (dv != 0)
				p = p / dv;
			else
				p = (sh < 64) ? (p >> sh) : 0;
			k++;
		end
		return sum;
	endfunction

	function automatic longint round_q60(longint v, int bits);
		int s = 60 - bits;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void build_constants();
		longint quarter, pi60;
		longint unsigned prod, amp;
		quarter = arctan_series(64'd1 << 59, 2, 0) + arctan_series((64'd1 << 60) / 3, 0, 9);
		pi60 = 4 * quarter;
		atan_q30[0] = round_q60(quarter, 30);
		for (int i = 1; i < NITER; i++)
			atan_q30[i] = round_q60(arctan_series(64'd1 << (60 - i), 2 * i, 0), 30);
		pi_q30 = round_q60(pi60, 30);
		halfpi_q30 = round_q60(pi60, 29);
		pi_q29 = round_q60(pi60, 29);
		prod = 64'd1 << 63;
		for (int i = 1; i < NITER; i++)
			prod += prod >> (2 * i);
		amp = int_sqrt(prod);
		gain_q30 = longint'(((64'd1 << 61) + amp / 2) / amp);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint reduce_angle(longint raw);
		longint r;
		r = raw % (2 * pi_q29);
		if (r > pi_q29)
			r -= 2 * pi_q29;
		if (r < -pi_q29)
			r += 2 * pi_q29;
		return r * 2;
	endfunction

	function automatic void rot_sin_cos(input longint t, output longint s, output longint c);
		longint x, y, nx;
		bit flip;
		x = gain_q30;
		y = 0;
		flip = 0;
		if (t > halfpi_q30) begin
			t -= pi_q30;
			flip = 1;
		end else if (t < -halfpi_q30) begin
			t += pi_q30;
			flip = 1;
		end
		for (int i = 0; i < NITER; i++) begin
			if (t >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				t -= atan_q30[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				t += atan_q30[i];
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic longint vec_atan2(longint y, longint x);
		longint z, nx;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? pi_q30 : -pi_q30;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < NITER; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_q30[i];
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_q30[i];
			end
			x = nx;
		end
		return z;
	endfunction

	function automatic pa_result_t parallactic(logic [31:0] ha, logic [30:0] dec, logic [30:0] lat);
		longint sh, ch, sd, cd, sl, cl, s_term, c_term, a;
		pa_result_t r;
		rot_sin_cos(reduce_angle(longint'(signed'(ha))), sh, ch);
		rot_sin_cos(reduce_angle(longint'(signed'(dec))), sd, cd);
		rot_sin_cos(reduce_angle(longint'(signed'(lat))), sl, cl);
		s_term = qmul(cl, sh);
		c_term = qmul(sl, cd) - qmul(qmul(cl, sd), ch);
		if (s_term == 0 && c_term == 0) begin
			r.angle = '0;
			r.pole = 1;
			return r;
		end
		a = (vec_atan2(s_term, c_term) + 1) >>> 1;
		if (a > pi_q29)
			a = pi_q29;
		if (a < -pi_q29)
			a = -pi_q29;
		r.angle = a[31:0];
		r.pole = 0;
		return r;
	endfunction

	always @(posedge clk) begin
		if (steady || $urandom_range(99) >= 29)
			out_ready <= 1;
		else
			out_ready <= 0;
	end

	always @(posedge clk) begin
		pa_result_t e;
		if (out_valid && out_ready) begin
			if (angle_q.size() == 0) begin
				$error("angle: result with no transaction pending, got %h", angle);
				fails++;
			end else begin
				e = angle_q.pop_front();
				if (angle !== e.angle) begin
					$error("angle: expected %h, actual %h", e.angle, angle);
					fails++;
				end
				if (at_pole !== e.pole) begin
					$error("at_pole: expected %b, actual %b", e.pole, at_pole);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			wd <= 0;
		else
			wd <= wd + 1;
		if (wd >= WATCHDOG_LIMIT) begin
			$display("parallactic_angle: mismatch");
			$finish;
		end
	end

	task automatic send_coord(logic [31:0] ha, logic [30:0] dec);
		while (!steady && $urandom_range(99) < 29) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		hour_angle <= ha;
		declination <= dec;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		angle_q.push_back(parallactic(ha, dec, lat_reg));
	endtask

	task automatic drain_pipe();
		in_valid <= 0;
		while (angle_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic set_latitude(logic [30:0] v);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_LATITUDE;
		pwdata <= {v[30], v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		lat_reg = v;
		pwrite <= 0;
		penable <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		if (prdata[30:0] !== v) begin
			$error("latitude: expected %h, actual %h", v, prdata[30:0]);
			fails++;
		end
		psel <= 0;
		penable <= 0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_ha();
		if ($urandom_range(99) < 80)
			return 32'(longint'($urandom_range(32'd3373259426, 0)) - 1686629713);
		return $urandom;
	endfunction

	function automatic logic [30:0] rand_dec();
		if ($urandom_range(99) < 80)
			return 31'(longint'($urandom_range(2 * 843314857, 0)) - 843314857);
		return 31'($urandom);
	endfunction

	pa_coord_t directed[] = '{
		'{32'd0, 31'd0},
		'{32'sd1686629713, 31'd0},
		'{-32'sd1686629713, 31'd0},
		'{32'h7fffffff, 31'd0},
		'{32'h80000000, 31'd0},
		'{32'd0, 31'sd843314857},
		'{32'd0, -31'sd843314857},
		'{32'd0, 31'h3fffffff},
		'{32'd0, 31'h40000000},
		'{32'sd843314857, 31'sd843314857},
		'{-32'sd843314857, -31'sd843314857},
		'{32'sd1686629713, 31'sd843314857},
		'{32'hffffffff, 31'h7fffffff},
		'{32'd1, 31'd1},
		'{32'h55555555, 31'h2aaaaaaa},
		'{32'haaaaaaaa, 31'h55555555},
		'{32'sd421657428, -31'sd421657428},
		'{-32'sd1265000000, 31'sd600000000}
	};

	logic [30:0] lat_set[] = '{
		31'sd843314857, -31'sd843314857, 31'h3fffffff, 31'h40000000,
		31'd0, 31'h2aaaaaaa, 31'h55555555, 31'd0
	};

	initial begin
		build_constants();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i])
			send_coord(directed[i].ha, directed[i].dec);
		foreach (lat_set[p]) begin
			drain_pipe();
			if (p >= 5)
				set_latitude(31'(longint'($urandom_range(2 * 843314857, 0)) - 843314857));
			else
				set_latitude(lat_set[p]);
			foreach (directed[i])
				if (i < 6)
					send_coord(directed[i].ha, directed[i].dec);
			for (int n = 0; n < RANDOM_ITEMS / 8; n++) begin
				steady = (p == 3) && (n < 150);
				send_coord(rand_ha(), rand_dec());
			end
			steady = 0;
		end
		in_valid <= 0;
		while (angle_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
		if (fails == 0)
			$display("parallactic_angle: match");
		else
			$display("parallactic_angle: mismatch");
		$finish;
	end

endmodule
